/* design/fcr_pkg.sv */
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types, constants and command codes of the forwarding chain resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package fcr_pkg;

   localparam int MAX_RULES   = 64;
   localparam int FIELD_W     = 14;
   localparam int CMD_W       = 2;
   localparam int RULE_IDX_W  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W       = $clog2(MAX_RULES + 1);
   localparam int CHAIN_DEPTH = MAX_RULES + 1;
   localparam int CHAIN_IDX_W = $clog2(CHAIN_DEPTH);
   localparam int LEN_W       = $clog2(CHAIN_DEPTH + 1);
   localparam int REQ_DATA_W  = 4 * FIELD_W;
   localparam int RSP_FIELD_W = 3 * FIELD_W + 2;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [FIELD_W-1:0] LOOP_RING = FIELD_W'(9999);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_ADD     = 2'd1,
      CMD_RESOLVE = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RULE_RD,
      ST_RULE_CHK,
      ST_CHAIN_RD,
      ST_CHAIN_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] src;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] span;
      logic [FIELD_W-1:0] tgt;
   } rule_type;

   // controller -> datapath
   typedef struct packed {
      logic do_clear;
      logic do_add;
      logic start_resolve;
      logic rule_next;
      logic take_target;
      logic chain_next;
      logic append;
      logic set_loop;
      logic load_rsp;
   } dp_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic count_zero;
      logic rule_match;
      logic rule_last;
      logic chain_hit;
      logic chain_last;
   } dp_sts_type;

endpackage

`default_nettype wire

/* design/fcr_ctrl.sv */
// ----------------------------------------------------------------------------
// fcr_ctrl
// Sequencer for table updates and the rule/chain scan of a resolve.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_ctrl
   import fcr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire cmd_type    req_cmd,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire dp_sts_type sts,
   output dp_ctl_type      ctl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ctl          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_cmd)
                  CMD_CLEAR: ctl.do_clear = 1'b1;
                  CMD_ADD:   ctl.do_add   = 1'b1;
                  CMD_RESOLVE: begin
                     ctl.start_resolve = 1'b1;
                     state_in = sts.count_zero ? ST_DONE : ST_RULE_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_RULE_RD: state_in = ST_RULE_CHK;
         ST_RULE_CHK: begin
            if (sts.rule_match) begin
               ctl.take_target = 1'b1;
               state_in = ST_CHAIN_RD;
            end else if (sts.rule_last) begin
               state_in = ST_DONE;
            end else begin
               ctl.rule_next = 1'b1;
               state_in = ST_RULE_RD;
            end
         end
         ST_CHAIN_RD: state_in = ST_CHAIN_CHK;
         ST_CHAIN_CHK: begin
            if (sts.chain_hit) begin
               ctl.set_loop = 1'b1;
               state_in = ST_DONE;
            end else if (sts.chain_last) begin
               ctl.append = 1'b1;
               state_in = ST_RULE_RD;
            end else begin
               ctl.chain_next = 1'b1;
               state_in = ST_CHAIN_RD;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* design/fcr_datapath.sv */
// ----------------------------------------------------------------------------
// fcr_datapath
// Rule table, chain store, scan counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_datapath
   import fcr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_ctl_type         ctl,
   input  wire logic [FIELD_W-1:0] in_ext,
   input  wire logic [FIELD_W-1:0] in_when,
   input  wire logic [FIELD_W-1:0] in_span,
   input  wire logic [FIELD_W-1:0] in_dest,
   output dp_sts_type              sts,
   output logic [FIELD_W-1:0]      out_call_time,
   output logic [FIELD_W-1:0]      out_dialed,
   output logic [FIELD_W-1:0]      out_rings,
   output logic                    out_looped,
   output logic                    out_overflowed
);

   rule_type           rule_mem [MAX_RULES];
   logic [FIELD_W-1:0] chain_mem [CHAIN_DEPTH];

   rule_type           rule_rd_ff;
   logic [FIELD_W-1:0] chain_rd_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   rule_idx_ff, rule_idx_in;
   logic [LEN_W-1:0]   chain_idx_ff, chain_idx_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [FIELD_W-1:0] when_ff, when_in;
   logic [FIELD_W-1:0] ext_ff, ext_in;
   logic [FIELD_W-1:0] cur_ff, cur_in;
   logic [FIELD_W-1:0] tgt_ff, tgt_in;
   logic               loop_ff, loop_in;

   logic [FIELD_W-1:0] rsp_time_ff, rsp_dial_ff, rsp_ring_ff;
   logic               rsp_loop_ff, rsp_ovf_ff;

   logic               chain_we;
   logic [LEN_W-1:0]   chain_waddr;
   logic [FIELD_W-1:0] chain_wdata;
   logic               table_full;
   logic [FIELD_W:0]   window_end;

   assign table_full = (count_ff == CNT_W'(MAX_RULES));

   // rule table: one write port, registered read at the scan index
   always_ff @(posedge clock) begin
      if (ctl.do_add && !table_full) begin
         rule_mem[count_ff[RULE_IDX_W-1:0]] <= '{src: in_ext, start: in_when,
                                                span: in_span, tgt: in_dest};
      end
      rule_rd_ff <= rule_mem[rule_idx_ff[RULE_IDX_W-1:0]];
   end

   always_comb begin
      chain_we    = ctl.start_resolve | ctl.append;
      chain_waddr = ctl.start_resolve ? '0 : len_ff;
      chain_wdata = ctl.start_resolve ? in_ext : tgt_ff;
   end

   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[chain_waddr[CHAIN_IDX_W-1:0]] <= chain_wdata;
      end
      chain_rd_ff <= chain_mem[chain_idx_ff[CHAIN_IDX_W-1:0]];
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rule_idx_in  = rule_idx_ff;
      chain_idx_in = chain_idx_ff;
      len_in       = len_ff;
      when_in      = when_ff;
      ext_in       = ext_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      loop_in      = loop_ff;
      if (ctl.do_clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
      if (ctl.do_add) begin
         if (table_full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (ctl.start_resolve) begin
         when_in     = in_when;
         ext_in      = in_ext;
         cur_in      = in_ext;
         len_in      = LEN_W'(1);
         rule_idx_in = '0;
         loop_in     = 1'b0;
      end
      if (ctl.rule_next) begin
         rule_idx_in = rule_idx_ff + 1'b1;
      end
      if (ctl.take_target) begin
         tgt_in       = rule_rd_ff.tgt;
         chain_idx_in = '0;
      end
      if (ctl.chain_next) begin
         chain_idx_in = chain_idx_ff + 1'b1;
      end
      if (ctl.append) begin
         len_in      = len_ff + 1'b1;
         cur_in      = tgt_ff;
         rule_idx_in = '0;
      end
      if (ctl.set_loop) begin
         loop_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      rule_idx_ff  <= rule_idx_in;
      chain_idx_ff <= chain_idx_in;
      len_ff       <= len_in;
      when_ff      <= when_in;
      ext_ff       <= ext_in;
      cur_ff       <= cur_in;
      tgt_ff       <= tgt_in;
      loop_ff      <= loop_in;
   end

   // window end is one bit wider so it never wraps
   assign window_end = {1'b0, rule_rd_ff.start} + {1'b0, rule_rd_ff.span};

   always_comb begin
      sts.count_zero = (count_ff == '0);
      sts.rule_match = (rule_rd_ff.src == cur_ff) && (when_ff >= rule_rd_ff.start) &&
                       ({1'b0, when_ff} <= window_end);
      sts.rule_last  = ((rule_idx_ff + 1'b1) == count_ff);
      sts.chain_hit  = (chain_rd_ff == tgt_ff);
      sts.chain_last = ((chain_idx_ff + 1'b1) == len_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_time_ff <= when_ff;
         rsp_dial_ff <= ext_ff;
         rsp_ring_ff <= loop_ff ? LOOP_RING : cur_ff;
         rsp_loop_ff <= loop_ff;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign out_call_time  = rsp_time_ff;
   assign out_dialed     = rsp_dial_ff;
   assign out_rings      = rsp_ring_ff;
   assign out_looped     = rsp_loop_ff;
   assign out_overflowed = rsp_ovf_ff;

endmodule

`default_nettype wire

/* design/forwarding_chain_resolver_core.sv */
// ----------------------------------------------------------------------------
// forwarding_chain_resolver_core
// Call forwarding table with a sequential chain resolver.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one command item. tuser holds the command: clear
//   the rule table, add a rule, or resolve a call. Clear and add complete in
//   the accept cycle and return nothing; adds beyond the table size are
//   dropped and set a sticky overflow flag reported with later results.
//   A resolve returns exactly one item on the rsp channel.
//   Steps of a resolve: each rule examined takes a registered read of the
//   rule table, then a compare, and each chain entry compared against a new
//   target takes a registered read of the chain store, then a compare;
//   the result is then loaded into the output register. The rule table
//   scan sets the resolve time. Only one resolve is in flight;
//   req_tready drops from accept until the result is loaded.
//   The result sits in an output register: while the receiver stalls, the
//   block keeps taking clears and adds, and a further resolve waits in its
//   final state until the register is free.
//   Reset empties the table, clears the overflow flag and drops any pending
//   result. Table contents need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module forwarding_chain_resolver_core
   import fcr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // ext [13:0], when [27:14], span [41:28], dest [55:42]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  wire logic [CMD_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // call_time [13:0], dialed [27:14], rings [41:28], looped [42],
   // overflowed [43], zero fill above
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   dp_ctl_type         ctl;
   dp_sts_type         sts;
   logic               req_ready;
   logic [FIELD_W-1:0] out_call_time, out_dialed, out_rings;
   logic               out_looped, out_overflowed;

   fcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (cmd_type'(req_tuser)),
      .req_ready (req_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .ctl       (ctl)
   );

   fcr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .in_ext         (req_tdata[FIELD_W-1:0]),
      .in_when        (req_tdata[2*FIELD_W-1:FIELD_W]),
      .in_span        (req_tdata[3*FIELD_W-1:2*FIELD_W]),
      .in_dest        (req_tdata[4*FIELD_W-1:3*FIELD_W]),
      .sts            (sts),
      .out_call_time  (out_call_time),
      .out_dialed     (out_dialed),
      .out_rings      (out_rings),
      .out_looped     (out_looped),
      .out_overflowed (out_overflowed)
   );

   assign req_tready = req_ready;
   assign rsp_tdata  = RSP_DATA_W'({out_overflowed, out_looped, out_rings,
                                    out_dialed, out_call_time});

   // clears, adds and idle codes return to ready in the cycle after they are taken
   a_update_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != CMD_RESOLVE) |=> req_tready)
      else $error("table update did not return to ready");

   // a resolve holds off further items
   a_resolve_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_RESOLVE) |=> !req_tready)
      else $error("ready during resolve");

   // a looped result always rings the loop extension
   a_loop_ring: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (!out_looped || out_rings == LOOP_RING))
      else $error("loop result with wrong ring extension");

endmodule

`default_nettype wire

/* bench/tb_forwarding_chain_resolver_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_forwarding_chain_resolver_core
// Self-checking bench for the call forwarding chain resolver.
// ----------------------------------------------------------------------------
// Drives clear, add and resolve commands (plus the unused code) into the
// request stream and keeps a shadow rule table to work out, for every
// accepted resolve, which extension should ring. Returned items are checked
// in order, field by field. Directed cases cover the window edges, loops,
// first-match order and table overflow; random sessions then build small
// tables over a narrow pool of extensions so that chains actually form.
// Both stream sides stall at random, the receiver once holds off long
// enough to back the block up, and the final stretch runs without gaps.
// ----------------------------------------------------------------------------

module tb_forwarding_chain_resolver_core;
   import fcr_pkg::*;

   // one returned item; member order matches rsp_tdata from bit 43 down
   typedef struct packed {
      logic               overflowed;
      logic               looped;
      logic [FIELD_W-1:0] rings;
      logic [FIELD_W-1:0] dialed;
      logic [FIELD_W-1:0] call_time;
   } ring_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // ext [13:0], when [27:14], span [41:28], dest [55:42]
   logic [REQ_DATA_W-1:0] req_tdata;
   // cmd [1:0]
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // call_time [13:0], dialed [27:14], rings [41:28], looped [42],
   // overflowed [43], zero fill above
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the forwarding table
   logic [FIELD_W-1:0] fwd_src   [MAX_RULES];
   logic [FIELD_W-1:0] fwd_start [MAX_RULES];
   logic [FIELD_W-1:0] fwd_span  [MAX_RULES];
   logic [FIELD_W-1:0] fwd_tgt   [MAX_RULES];
   int                 fwd_count    = 0;
   bit                 fwd_overflow = 1'b0;

   ring_result_type pending_rings[$];
   int              errors       = 0;
   int              items_sent   = 0;
   int              rx_hold_left = 0;
   bit              calm         = 1'b0;

   forwarding_chain_resolver_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic note_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   // Offer one item, wait for the handshake, then update the shadow table or
   // queue the expected ringing extension. Entered and left at a falling edge.
   task automatic send_item(input cmd_type cmd, input logic [FIELD_W-1:0] ext,
                            input logic [FIELD_W-1:0] call_at,
                            input logic [FIELD_W-1:0] span,
                            input logic [FIELD_W-1:0] dest);
      ring_result_type    want;
      logic [FIELD_W-1:0] hops[$];
      int                 j;
      bit                 seen;
      int unsigned        win_end;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {dest, span, call_at, ext};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (cmd)
         CMD_CLEAR: begin
            fwd_count    = 0;
            fwd_overflow = 1'b0;
         end
         CMD_ADD: begin
            if (fwd_count >= MAX_RULES) begin
               fwd_overflow = 1'b1;
            end else begin
               fwd_src[fwd_count]   = ext;
               fwd_start[fwd_count] = call_at;
               fwd_span[fwd_count]  = span;
               fwd_tgt[fwd_count]   = dest;
               fwd_count++;
            end
         end
         CMD_RESOLVE: begin
            // follow the chain: first matching rule wins, restart at rule zero
            hops.push_back(ext);
            j           = 0;
            want.looped = 1'b0;
            while (j < fwd_count && !want.looped) begin
               win_end = 32'(fwd_start[j]) + 32'(fwd_span[j]);
               if (fwd_src[j] == hops[$] && call_at >= fwd_start[j] &&
                   call_at <= win_end) begin
                  seen = 1'b0;
                  foreach (hops[k]) if (hops[k] == fwd_tgt[j]) seen = 1'b1;
                  if (seen) begin
                     want.looped = 1'b1;
                  end else begin
                     hops.push_back(fwd_tgt[j]);
                     j = 0;
                  end
               end else begin
                  j++;
               end
            end
            want.call_time  = call_at;
            want.dialed     = ext;
            want.rings      = want.looped ? LOOP_RING : hops[$];
            want.overflowed = fwd_overflow;
            pending_rings.push_back(want);
         end
         default: ;
      endcase
      if (cmd != CMD_NOP) items_sent++;
      @(negedge clock);
   endtask

   // Hold the request side idle until every queued result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_rings.size() != 0);
   endtask

   // Random sessions: mostly clear, build a table over a pool of five neighboring
   // extensions and a narrow time band, then dial into it. Mix in noise.
   task automatic run_sessions(input int target);
      int                 stop_at;
      int                 n_rules;
      int                 n_calls;
      logic [FIELD_W-1:0] ext_base;
      logic [FIELD_W-1:0] t_base;
      logic [FIELD_W-1:0] pool [5];
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         ext_base = FIELD_W'($urandom);
         t_base   = FIELD_W'($urandom_range(0, 16300));
         for (int k = 0; k < 5; k++) pool[k] = FIELD_W'(ext_base + k);
         if ($urandom_range(0, 5) != 0)
            send_item(CMD_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom),
                      FIELD_W'($urandom), FIELD_W'($urandom));
         n_rules = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
                                               : $urandom_range(1, 12);
         for (int k = 0; k < n_rules; k++) begin
            if ($urandom_range(0, 11) == 0)
               send_item(cmd_type'($urandom_range(0, 3)), FIELD_W'($urandom),
                         FIELD_W'($urandom), FIELD_W'($urandom),
                         FIELD_W'($urandom));
            send_item(CMD_ADD, pool[$urandom_range(0, 4)],
                      FIELD_W'(t_base + $urandom_range(0, 40)),
                      ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom)
                                                  : FIELD_W'($urandom_range(0, 40)),
                      ($urandom_range(0, 5) == 0) ? FIELD_W'($urandom)
                                                  : pool[$urandom_range(0, 4)]);
         end
         n_calls = $urandom_range(2, 8);
         for (int k = 0; k < n_calls; k++)
            send_item(CMD_RESOLVE,
                      ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom)
                                                  : pool[$urandom_range(0, 4)],
                      ($urandom_range(0, 9) == 0) ? FIELD_W'($urandom)
                                 : FIELD_W'(t_base + $urandom_range(0, 80)),
                      FIELD_W'($urandom), FIELD_W'($urandom));
      end
   endtask

   task automatic test_directed_cases();
      // empty table: the dialed extension rings
      send_item(CMD_RESOLVE, 0, 0, 0, 0);
      send_item(CMD_RESOLVE, 16383, 16383, 16383, 16383);
      // zero-length window holds only its start time
      send_item(CMD_ADD, 0, 0, 0, 16383);
      send_item(CMD_RESOLVE, 0, 0, 0, 0);
      send_item(CMD_RESOLVE, 0, 1, 0, 0);
      // window end beyond the field range must not wrap
      send_item(CMD_ADD, 16383, 16383, 16383, 5);
      send_item(CMD_RESOLVE, 16383, 16383, 0, 0);
      // two-hop loop, window inclusive at both ends
      send_item(CMD_ADD, 7, 100, 100, 8);
      send_item(CMD_ADD, 8, 100, 100, 7);
      send_item(CMD_RESOLVE, 7, 150, 0, 0);
      send_item(CMD_RESOLVE, 7, 200, 0, 0);
      send_item(CMD_RESOLVE, 7, 201, 0, 0);
      // rule forwarding to itself
      send_item(CMD_ADD, 9, 0, 9999, 9);
      send_item(CMD_RESOLVE, 9, 42, 0, 0);
      // earlier rule wins, and the search restarts at rule zero after a hop
      send_item(CMD_ADD, 32, 0, 9999, 33);
      send_item(CMD_ADD, 31, 0, 9999, 32);
      send_item(CMD_ADD, 31, 0, 9999, 40);
      send_item(CMD_RESOLVE, 31, 5, 0, 0);
      // a real forward to the loop marker value is not a loop
      send_item(CMD_ADD, 50, 0, 0, 9999);
      send_item(CMD_RESOLVE, 50, 0, 0, 0);
      // unused code changes nothing
      send_item(CMD_NOP, 16383, 16383, 16383, 16383);
      send_item(CMD_RESOLVE, 16383, 16383, 0, 0);
      send_item(CMD_CLEAR, 16383, 16383, 16383, 16383);
      send_item(CMD_RESOLVE, 7, 150, 0, 0);
   endtask

   task automatic test_table_overflow();
      send_item(CMD_CLEAR, 0, 0, 0, 0);
      // 64-hop linear chain stored backwards: every hop scans far
      for (int k = MAX_RULES - 1; k >= 0; k--)
         send_item(CMD_ADD, FIELD_W'(100 + k), 500, 100, FIELD_W'(101 + k));
      send_item(CMD_RESOLVE, 100, 550, 0, 0);
      // adds on a full table are dropped
      for (int k = 0; k < 3; k++)
         send_item(CMD_ADD, FIELD_W'(100 + MAX_RULES), 500, 100, 9000);
      send_item(CMD_RESOLVE, 100, 600, 0, 0);
      send_item(CMD_RESOLVE, 100, 601, 0, 0);
      send_item(CMD_CLEAR, 0, 0, 0, 0);
      send_item(CMD_RESOLVE, 100, 550, 0, 0);
   endtask

   task automatic test_output_stall();
      send_item(CMD_CLEAR, 0, 0, 0, 0);
      send_item(CMD_ADD, 1, 0, 50, 2);
      send_item(CMD_ADD, 2, 0, 50, 3);
      // stall the receiver while resolves and adds keep coming
      rx_hold_left = 400;
      for (int k = 0; k < 6; k++) begin
         send_item(CMD_RESOLVE, 1, FIELD_W'(10 * k), 0, 0);
         send_item(CMD_ADD, 3, 0, 50, FIELD_W'(4 + k));
      end
      drain_results();
   endtask

   task automatic test_random_traffic();
      run_sessions(520);
      drain_results();
   endtask

   task automatic test_steady_stream();
      calm = 1'b1;
      run_sessions(110);
   endtask

   // Receiver: random short stalls, plus a long hold-off when requested.
   initial begin : rsp_sink
      int burst_left;
      burst_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (rx_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rx_hold_left--;
         end else if (burst_left > 0) begin
            rsp_tready <= 1'b0;
            burst_left--;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            burst_left = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare every returned item with the oldest expectation.
   initial begin : rsp_check
      ring_result_type got;
      ring_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(ring_result_type)-1:0];
            if (pending_rings.size() == 0) begin
               note_error($sformatf("unexpected result, dialed %0d rings %0d",
                                    got.dialed, got.rings));
            end else begin
               want = pending_rings.pop_front();
               if (got.call_time !== want.call_time)
                  note_error($sformatf("call_time got %0d want %0d",
                                       got.call_time, want.call_time));
               if (got.dialed !== want.dialed)
                  note_error($sformatf("dialed got %0d want %0d",
                                       got.dialed, want.dialed));
               if (got.rings !== want.rings)
                  note_error($sformatf("rings got %0d want %0d (dialed %0d at %0d)",
                                       got.rings, want.rings, want.dialed,
                                       want.call_time));
               if (got.looped !== want.looped)
                  note_error($sformatf("looped got %0b want %0b (dialed %0d)",
                                       got.looped, want.looped, want.dialed));
               if (got.overflowed !== want.overflowed)
                  note_error($sformatf("overflowed got %0b want %0b (dialed %0d)",
                                       got.overflowed, want.overflowed,
                                       want.dialed));
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_CLEAR;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_cases();
      test_table_overflow();
      test_output_stall();
      test_random_traffic();
      test_steady_stream();
      drain_results();
      // let any stray result show up before judging
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #1s;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
